@@ rtl/mrcs_pkg.sv @@
// Shared constants, command codes and pattern tables for the modem response block.
package mrcs_pkg;

   // Longest line that is still tracked; further characters are dropped.
   localparam logic [7:0] LINE_SIZE = 8'd128;

   // Reset value of the connect timeout register, in frame ticks.
   localparam logic [15:0] CONNECT_TIMEOUT_RESET = 16'd1500;

   // Command codes carried by an input item.
   localparam logic [2:0] CMD_RX_BYTE = 3'd0;
   localparam logic [2:0] CMD_TICK    = 3'd1;
   localparam logic [2:0] CMD_PLACE   = 3'd2;
   localparam logic [2:0] CMD_ANSWER  = 3'd3;
   localparam logic [2:0] CMD_HANGUP  = 3'd4;
   localparam logic [2:0] CMD_MUTE    = 3'd5;
   localparam logic [2:0] CMD_CLEAR   = 3'd6;

   // Line classes reported with a finished line.
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_OK    = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_CMGL  = 2'd3;

   // Bit positions in the set of patterns that can still match.
   localparam int unsigned M_CMGL  = 0;
   localparam int unsigned M_OK    = 1;
   localparam int unsigned M_ERROR = 2;

   // Line terminators.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Character of "+CMGL" at a position below five.
   function automatic logic [7:0] cmgl_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0: ch = 8'h2B;
         3'd1: ch = 8'h43;
         3'd2: ch = 8'h4D;
         3'd3: ch = 8'h47;
         3'd4: ch = 8'h4C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Character of "ERROR" at a position below five.
   function automatic logic [7:0] error_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0: ch = 8'h45;
         3'd1: ch = 8'h52;
         3'd2: ch = 8'h52;
         3'd3: ch = 8'h4F;
         3'd4: ch = 8'h52;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Character of "OK" at a position below two.
   function automatic logic [7:0] ok_char(input logic pos);
      return pos ? 8'h4B : 8'h4F;
   endfunction

endpackage

@@ rtl/mrcs_channels.sv @@
// Valid/ready channel interfaces for request and response items.
interface mrcs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mrcs_rsp_if;
   logic        valid;
   logic        ready;
   logic        line_done;
   logic [1:0]  line_kind;
   logic [15:0] entry_count;
   logic        ok_seen;
   logic        error_seen;
   logic [1:0]  call_phase;
   logic        mute_on;
   logic        timed_out;

   modport source (output valid, output line_done, output line_kind, output entry_count,
                   output ok_seen, output error_seen, output call_phase, output mute_on,
                   output timed_out, input ready);
   modport sink (input valid, input line_done, input line_kind, input entry_count,
                 input ok_seen, input error_seen, input call_phase, input mute_on,
                 input timed_out, output ready);
endinterface

@@ rtl/modem_response_and_call_state.sv @@
// Modem response line classifier and call state machine, top level.
// Every request item produces exactly one response item, registered in the cycle after it is
// accepted, and one item can be accepted in every clock cycle: the block is
// ready whenever its response register is empty or is being taken in the same
// cycle, so throughput is set only by the response register. Received bytes
// are matched against "+CMGL", "OK" and "ERROR" on the fly, one character per
// item, so no line buffer is kept. The connect timeout register may only be
// written while no item is in flight.
module modem_response_and_call_state (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   mrcs_req_if.sink          req_ch,
   mrcs_rsp_if.source        rsp_ch
);

   typedef enum logic [1:0] {
      PH_DISCONNECTED = 2'd0,
      PH_CONNECTING   = 2'd1,
      PH_RINGING      = 2'd2,
      PH_CONNECTED    = 2'd3
   } phase_type;

   // Configuration and state registers.
   logic [15:0] timeout_cfg_ff;
   logic [7:0]  line_count_ff, line_count_in;
   logic        line_restart_ff, line_restart_in;
   logic [2:0]  match_flags_ff, match_flags_in;
   logic        zero_seen_ff, zero_seen_in;
   logic [15:0] entry_total_ff, entry_total_in;
   logic        ok_flag_ff, ok_flag_in;
   logic        error_flag_ff, error_flag_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] deadline_ff, deadline_in;
   phase_type   phase_ff, phase_in;
   logic        mute_ff, mute_in;

   // Response register.
   logic        rsp_valid_ff;
   logic        line_done_ff, line_done_in;
   logic [1:0]  line_kind_ff, line_kind_in;
   logic        timed_out_ff, timed_out_in;

   // Line tracking working values.
   logic [7:0]  base_count;
   logic [2:0]  base_flags;
   logic        base_zero;
   logic [2:0]  fin_flags;
   logic [15:0] tick_sum;
   logic        accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign tick_sum     = tick_count_ff + 16'd1;

   // Next state and result for the item at the input.
   always_comb begin
      line_count_in   = line_count_ff;
      line_restart_in = line_restart_ff;
      match_flags_in  = match_flags_ff;
      zero_seen_in    = zero_seen_ff;
      entry_total_in  = entry_total_ff;
      ok_flag_in      = ok_flag_ff;
      error_flag_in   = error_flag_ff;
      tick_count_in   = tick_count_ff;
      deadline_in     = deadline_ff;
      phase_in        = phase_ff;
      mute_in         = mute_ff;
      line_done_in    = 1'b0;
      line_kind_in    = mrcs_pkg::KIND_OTHER;
      timed_out_in    = 1'b0;

      // A byte after a finished line starts a fresh line first.
      base_count = line_restart_ff ? 8'd0 : line_count_ff;
      base_flags = line_restart_ff ? 3'b111 : match_flags_ff;
      base_zero  = line_restart_ff ? 1'b0 : zero_seen_ff;

      // Length check applied when a line ends without a zero byte.
      fin_flags = base_flags;
      if (!base_zero) begin
         if (base_count < 8'd5) fin_flags[mrcs_pkg::M_CMGL] = 1'b0;
         if (base_count != 8'd2) fin_flags[mrcs_pkg::M_OK] = 1'b0;
         if (base_count != 8'd5) fin_flags[mrcs_pkg::M_ERROR] = 1'b0;
      end

      unique case (req_ch.cmd)
         mrcs_pkg::CMD_RX_BYTE: begin
            line_count_in   = base_count;
            match_flags_in  = base_flags;
            zero_seen_in    = base_zero;
            line_restart_in = 1'b0;
            if (req_ch.rx_byte == mrcs_pkg::CHAR_CR || req_ch.rx_byte == mrcs_pkg::CHAR_LF) begin
               // End of line: class it unless it is empty.
               if (base_count != 8'd0) begin
                  line_done_in    = 1'b1;
                  line_restart_in = 1'b1;
                  match_flags_in  = fin_flags;
                  priority if (fin_flags[mrcs_pkg::M_CMGL]) begin
                     entry_total_in = entry_total_ff + 16'd1;
                     line_kind_in   = mrcs_pkg::KIND_CMGL;
                  end else if (fin_flags[mrcs_pkg::M_OK]) begin
                     ok_flag_in   = 1'b1;
                     line_kind_in = mrcs_pkg::KIND_OK;
                  end else if (fin_flags[mrcs_pkg::M_ERROR]) begin
                     error_flag_in = 1'b1;
                     line_kind_in  = mrcs_pkg::KIND_ERROR;
                  end else begin
                     line_kind_in = mrcs_pkg::KIND_OTHER;
                  end
               end
            end else if (base_count < mrcs_pkg::LINE_SIZE) begin
               // Ordinary character: narrow down the patterns still possible.
               line_count_in = base_count + 8'd1;
               if (!base_zero) begin
                  if (req_ch.rx_byte == 8'h00) begin
                     zero_seen_in = 1'b1;
                     if (base_count < 8'd5) match_flags_in[mrcs_pkg::M_CMGL] = 1'b0;
                     if (base_count != 8'd2) match_flags_in[mrcs_pkg::M_OK] = 1'b0;
                     if (base_count != 8'd5) match_flags_in[mrcs_pkg::M_ERROR] = 1'b0;
                  end else begin
                     if (base_count < 8'd5 &&
                         req_ch.rx_byte != mrcs_pkg::cmgl_char(base_count[2:0]))
                        match_flags_in[mrcs_pkg::M_CMGL] = 1'b0;
                     if (base_count >= 8'd2 ||
                         req_ch.rx_byte != mrcs_pkg::ok_char(base_count[0]))
                        match_flags_in[mrcs_pkg::M_OK] = 1'b0;
                     if (base_count >= 8'd5 ||
                         req_ch.rx_byte != mrcs_pkg::error_char(base_count[2:0]))
                        match_flags_in[mrcs_pkg::M_ERROR] = 1'b0;
                  end
               end
            end
         end
         mrcs_pkg::CMD_TICK: begin
            // Frame tick: advance the counter and check the armed deadline.
            tick_count_in = tick_sum;
            if (deadline_ff != 16'd0 && tick_sum >= deadline_ff) begin
               deadline_in  = 16'd0;
               timed_out_in = 1'b1;
               if (phase_ff == PH_CONNECTING || phase_ff == PH_RINGING) begin
                  phase_in = PH_DISCONNECTED;
                  mute_in  = 1'b0;
               end
            end
         end
         mrcs_pkg::CMD_PLACE: begin
            phase_in      = PH_CONNECTING;
            tick_count_in = 16'd0;
            deadline_in   = timeout_cfg_ff;
         end
         mrcs_pkg::CMD_ANSWER: begin
            if (phase_ff == PH_RINGING) begin
               phase_in    = PH_CONNECTED;
               deadline_in = 16'd0;
            end
         end
         mrcs_pkg::CMD_HANGUP: begin
            if (phase_ff != PH_DISCONNECTED) begin
               phase_in    = PH_DISCONNECTED;
               deadline_in = 16'd0;
               mute_in     = 1'b0;
            end
         end
         mrcs_pkg::CMD_MUTE: begin
            mute_in = !mute_ff;
         end
         mrcs_pkg::CMD_CLEAR: begin
            ok_flag_in     = 1'b0;
            error_flag_in  = 1'b0;
            entry_total_in = 16'd0;
         end
         default: begin
         end
      endcase
   end

   // State, configuration and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_cfg_ff  <= mrcs_pkg::CONNECT_TIMEOUT_RESET;
         line_count_ff   <= 8'd0;
         line_restart_ff <= 1'b0;
         match_flags_ff  <= 3'b111;
         zero_seen_ff    <= 1'b0;
         entry_total_ff  <= 16'd0;
         ok_flag_ff      <= 1'b0;
         error_flag_ff   <= 1'b0;
         tick_count_ff   <= 16'd0;
         deadline_ff     <= 16'd0;
         phase_ff        <= PH_DISCONNECTED;
         mute_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_cfg_ff <= csr_wr_data;
         end
         if (accept) begin
            line_count_ff   <= line_count_in;
            line_restart_ff <= line_restart_in;
            match_flags_ff  <= match_flags_in;
            zero_seen_ff    <= zero_seen_in;
            entry_total_ff  <= entry_total_in;
            ok_flag_ff      <= ok_flag_in;
            error_flag_ff   <= error_flag_in;
            tick_count_ff   <= tick_count_in;
            deadline_ff     <= deadline_in;
            phase_ff        <= phase_in;
            mute_ff         <= mute_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-item result fields; status fields are read from the state registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         line_done_ff <= line_done_in;
         line_kind_ff <= line_kind_in;
         timed_out_ff <= timed_out_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.line_done   = line_done_ff;
   assign rsp_ch.line_kind   = line_kind_ff;
   assign rsp_ch.entry_count = entry_total_ff;
   assign rsp_ch.ok_seen     = ok_flag_ff;
   assign rsp_ch.error_seen  = error_flag_ff;
   assign rsp_ch.call_phase  = phase_ff;
   assign rsp_ch.mute_on     = mute_ff;
   assign rsp_ch.timed_out   = timed_out_ff;

   // A line is only marked for restart after it held at least one character.
   a_restart_nonempty: assert property (@(posedge clock) disable iff (reset)
      line_restart_ff |-> line_count_ff != 8'd0)
      else $error("line restart pending on an empty line");

   // A zero byte is always counted as a character of the line.
   a_zero_nonempty: assert property (@(posedge clock) disable iff (reset)
      zero_seen_ff |-> line_count_ff != 8'd0)
      else $error("zero byte flagged on an empty line");

   // A reported timeout has disarmed the deadline.
   a_timeout_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && timed_out_ff |-> deadline_ff == 16'd0)
      else $error("deadline still armed after timeout");

   // Placing a call always enters connecting with a fresh tick count.
   a_place_connects: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.cmd == mrcs_pkg::CMD_PLACE
      |=> phase_ff == PH_CONNECTING && tick_count_ff == 16'd0)
      else $error("place call did not enter connecting");

   // Only a finished line carries a class other than other.
   a_kind_needs_done: assert property (@(posedge clock) disable iff (reset)
      accept && !line_done_in |=> line_kind_ff == mrcs_pkg::KIND_OTHER)
      else $error("line class reported without a finished line");

endmodule

@@ verif/mrcs_checker.sv @@
// Response checker for the modem response block: predicts every response item and compares.
module mrcs_checker (
   input  logic        clock,
   input  logic        reset,
   mrcs_req_if         req_mon,
   mrcs_rsp_if         rsp_mon,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          outstanding,
   output int          results_checked,
   output int          lines_closed,
   output int          timeouts_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      CALL_IDLE    = 2'd0,
      CALL_DIALING = 2'd1,
      CALL_RINGING = 2'd2,
      CALL_ACTIVE  = 2'd3
   } call_phase_type;

   typedef struct packed {
      logic        line_done;
      logic [1:0]  line_kind;
      logic [15:0] entry_count;
      logic        ok_seen;
      logic        error_seen;
      logic [1:0]  call_phase;
      logic        mute_on;
      logic        timed_out;
   } status_type;

   // Response texts that a finished line is matched against.
   localparam logic [39:0] CMGL_TEXT  = "+CMGL";
   localparam logic [15:0] OK_TEXT    = "OK";
   localparam logic [39:0] ERROR_TEXT = "ERROR";

   // Predicted state of the line tracker.
   logic [7:0]  text_len;
   logic        line_closed;
   logic [2:0]  live_patterns;
   logic        nul_hit;
   logic [15:0] entry_total;
   logic        ok_sticky;
   logic        error_sticky;

   // Predicted state of the call machine and the timeout register.
   logic [15:0]    frame_ticks;
   logic [15:0]    expiry;
   call_phase_type call_mode;
   logic           muted;
   logic [15:0]    timeout_ticks;

   status_type expected_q[$];

   initial begin
      fail_count = 0;
      outstanding = 0;
      results_checked = 0;
      lines_closed = 0;
      timeouts_seen = 0;
   end

   // Rule out patterns that the character at this position contradicts.
   function automatic void track_text(input int pos, input logic [7:0] ch);
      if (nul_hit) return;
      if (ch == 8'h00) begin
         // The compared text ends here, so only the length so far counts.
         nul_hit = 1'b1;
         if (pos < 5) live_patterns[mrcs_pkg::M_CMGL] = 1'b0;
         if (pos != 2) live_patterns[mrcs_pkg::M_OK] = 1'b0;
         if (pos != 5) live_patterns[mrcs_pkg::M_ERROR] = 1'b0;
         return;
      end
      if (pos < 5) begin
         if (ch != CMGL_TEXT[8*(4-pos) +: 8]) live_patterns[mrcs_pkg::M_CMGL] = 1'b0;
      end
      if (pos >= 2) begin
         live_patterns[mrcs_pkg::M_OK] = 1'b0;
      end else if (ch != OK_TEXT[8*(1-pos) +: 8]) begin
         live_patterns[mrcs_pkg::M_OK] = 1'b0;
      end
      if (pos >= 5) begin
         live_patterns[mrcs_pkg::M_ERROR] = 1'b0;
      end else if (ch != ERROR_TEXT[8*(4-pos) +: 8]) begin
         live_patterns[mrcs_pkg::M_ERROR] = 1'b0;
      end
   endfunction

   // Class a finished line; +CMGL is a prefix match, OK and ERROR are exact.
   function automatic logic [1:0] close_text();
      if (!nul_hit) begin
         if (text_len < 5) live_patterns[mrcs_pkg::M_CMGL] = 1'b0;
         if (text_len != 2) live_patterns[mrcs_pkg::M_OK] = 1'b0;
         if (text_len != 5) live_patterns[mrcs_pkg::M_ERROR] = 1'b0;
      end
      if (live_patterns[mrcs_pkg::M_CMGL]) begin
         entry_total = entry_total + 16'd1;
         return mrcs_pkg::KIND_CMGL;
      end
      if (live_patterns[mrcs_pkg::M_OK]) begin
         ok_sticky = 1'b1;
         return mrcs_pkg::KIND_OK;
      end
      if (live_patterns[mrcs_pkg::M_ERROR]) begin
         error_sticky = 1'b1;
         return mrcs_pkg::KIND_ERROR;
      end
      return mrcs_pkg::KIND_OTHER;
   endfunction

   function automatic void hang_up();
      if (call_mode != CALL_IDLE) begin
         call_mode = CALL_IDLE;
         expiry = 16'd0;
         muted = 1'b0;
      end
   endfunction

   // Advance the predicted state by one item and return the status it reports.
   function automatic status_type predict_status(input logic [2:0] op, input logic [7:0] ch);
      status_type s;
      s = '0;
      case (op)
         mrcs_pkg::CMD_RX_BYTE: begin
            if (line_closed) begin
               text_len = 8'd0;
               live_patterns = 3'b111;
               nul_hit = 1'b0;
               line_closed = 1'b0;
            end
            if (ch == mrcs_pkg::CHAR_CR || ch == mrcs_pkg::CHAR_LF) begin
               // A terminator on an empty line is ignored.
               if (text_len != 8'd0) begin
                  s.line_kind = close_text();
                  s.line_done = 1'b1;
                  line_closed = 1'b1;
               end
            end else if (text_len < mrcs_pkg::LINE_SIZE) begin
               track_text(int'(text_len), ch);
               text_len = text_len + 8'd1;
            end
         end
         mrcs_pkg::CMD_TICK: begin
            frame_ticks = frame_ticks + 16'd1;
            if (expiry != 16'd0 && frame_ticks >= expiry) begin
               expiry = 16'd0;
               s.timed_out = 1'b1;
               if (call_mode == CALL_DIALING || call_mode == CALL_RINGING) hang_up();
            end
         end
         mrcs_pkg::CMD_PLACE: begin
            call_mode = CALL_DIALING;
            frame_ticks = 16'd0;
            expiry = timeout_ticks;
         end
         mrcs_pkg::CMD_ANSWER: begin
            if (call_mode == CALL_RINGING) begin
               call_mode = CALL_ACTIVE;
               expiry = 16'd0;
            end
         end
         mrcs_pkg::CMD_HANGUP: hang_up();
         mrcs_pkg::CMD_MUTE: muted = !muted;
         mrcs_pkg::CMD_CLEAR: begin
            ok_sticky = 1'b0;
            error_sticky = 1'b0;
            entry_total = 16'd0;
         end
         default: ;
      endcase
      s.entry_count = entry_total;
      s.ok_seen = ok_sticky;
      s.error_seen = error_sticky;
      s.call_phase = call_mode;
      s.mute_on = muted;
      return s;
   endfunction

   function automatic string fmt_status(input status_type s);
      return $sformatf("done=%0d kind=%0d entries=%0d ok=%0d err=%0d phase=%0d mute=%0d tmo=%0d",
                       s.line_done, s.line_kind, s.entry_count, s.ok_seen, s.error_seen,
                       s.call_phase, s.mute_on, s.timed_out);
   endfunction

   // Count a failure; only the first few are described.
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   // Predict on every accepted request item, compare on every accepted response item.
   always @(posedge clock) begin
      status_type want;
      status_type got;
      if (reset) begin
         text_len = 8'd0;
         line_closed = 1'b0;
         live_patterns = 3'b111;
         nul_hit = 1'b0;
         entry_total = 16'd0;
         ok_sticky = 1'b0;
         error_sticky = 1'b0;
         frame_ticks = 16'd0;
         expiry = 16'd0;
         call_mode = CALL_IDLE;
         muted = 1'b0;
         timeout_ticks = mrcs_pkg::CONNECT_TIMEOUT_RESET;
         expected_q.delete();
      end else begin
         if (csr_wr_en) timeout_ticks = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            want = predict_status(req_mon.cmd, req_mon.rx_byte);
            if (want.line_done) lines_closed++;
            if (want.timed_out) timeouts_seen++;
            expected_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{line_done: rsp_mon.line_done, line_kind: rsp_mon.line_kind,
                    entry_count: rsp_mon.entry_count, ok_seen: rsp_mon.ok_seen,
                    error_seen: rsp_mon.error_seen, call_phase: rsp_mon.call_phase,
                    mute_on: rsp_mon.mute_on, timed_out: rsp_mon.timed_out};
            if (expected_q.size() == 0) begin
               note_failure({"response item with no request outstanding: ", fmt_status(got)});
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (got !== want) begin
                  note_failure({"status mismatch, expected ", fmt_status(want),
                                " got ", fmt_status(got)});
               end
            end
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

@@ verif/testbench.sv @@
// Top of the modem response testbench: clock, reset, stimulus, timeout writes and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The one command code that the block has no use for.
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEMS_PER_SETTING = 70;
   localparam int SETTING_COUNT = 7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   int fail_count;
   int outstanding;
   int results_checked;
   int lines_closed;
   int timeouts_seen;
   int items_sent = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   mrcs_req_if req_ch ();
   mrcs_rsp_if rsp_ch ();

   modem_response_and_call_state dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   mrcs_checker status_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .lines_closed    (lines_closed),
      .timeouts_seen   (timeouts_seen)
   );

   always #1 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: runs of ready separated by random stalls.
   initial begin
      int run_len;
      int stall_len;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= 1'b1;
         run_len = $urandom_range(1, 12);
         repeat (run_len - 1) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            @(posedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (stall_len - 1) @(posedge clock);
         end
      end
   end

   // Offer one request item after a random gap and hold it until accepted.
   task automatic send_item(input logic [2:0] op, input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= op;
      req_ch.rx_byte <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // A non-byte command carries a random, unused data byte.
   task automatic send_event(input logic [2:0] op);
      send_item(op, 8'($urandom_range(0, 255)));
   endtask

   // Send a text line, sometimes with a zero byte inside, ending in a random terminator or in none.
   task automatic send_line(input string body);
      int nul_at;
      int i;
      int pick;
      nul_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.len()) : -1;
      for (i = 0; i < body.len(); i++) begin
         if (i == nul_at) send_item(mrcs_pkg::CMD_RX_BYTE, 8'h00);
         send_item(mrcs_pkg::CMD_RX_BYTE, body[i]);
      end
      if (nul_at == body.len()) send_item(mrcs_pkg::CMD_RX_BYTE, 8'h00);
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         send_item(mrcs_pkg::CMD_RX_BYTE, mrcs_pkg::CHAR_CR);
      end else if (pick < 14) begin
         send_item(mrcs_pkg::CMD_RX_BYTE, mrcs_pkg::CHAR_LF);
      end else if (pick < 19) begin
         send_item(mrcs_pkg::CMD_RX_BYTE, mrcs_pkg::CHAR_CR);
         send_item(mrcs_pkg::CMD_RX_BYTE, mrcs_pkg::CHAR_LF);
      end
      // Otherwise the line runs on into the next one.
   endtask

   // Typical modem responses, near misses and random printable text.
   function automatic string pick_body();
      string s;
      int n;
      case ($urandom_range(0, 11))
         0, 1: s = "OK";
         2, 3: s = "ERROR";
         4, 5: s = $sformatf("+CMGL: %0d,\"REC UNREAD\"", $urandom_range(1, 40));
         6: s = "+CMGL";
         7: begin
            case ($urandom_range(0, 6))
               0: s = "OKAY";
               1: s = "O";
               2: s = "ERRORS";
               3: s = "ERRO";
               4: s = "+CMG";
               5: s = "ok";
               default: s = "+CMGX";
            endcase
         end
         8: s = "NO CARRIER";
         9: s = "RING";
         default: begin
            s = "";
            n = $urandom_range(1, 14);
            repeat (n) s = $sformatf("%s%c", s, $urandom_range(8'h20, 8'h7E));
         end
      endcase
      return s;
   endfunction

   // A line around or beyond the tracked size; any tail past it must be dropped.
   task automatic send_long_line();
      int n;
      logic [7:0] ch;
      if ($urandom_range(0, 1)) begin
         send_item(mrcs_pkg::CMD_RX_BYTE, "+");
         send_item(mrcs_pkg::CMD_RX_BYTE, "C");
         send_item(mrcs_pkg::CMD_RX_BYTE, "M");
         send_item(mrcs_pkg::CMD_RX_BYTE, "G");
         send_item(mrcs_pkg::CMD_RX_BYTE, "L");
      end
      n = $urandom_range(int'(mrcs_pkg::LINE_SIZE) - 2, int'(mrcs_pkg::LINE_SIZE) + 12);
      repeat (n) begin
         do ch = 8'($urandom_range(1, 255));
         while (ch == mrcs_pkg::CHAR_CR || ch == mrcs_pkg::CHAR_LF);
         send_item(mrcs_pkg::CMD_RX_BYTE, ch);
      end
      send_item(mrcs_pkg::CMD_RX_BYTE, mrcs_pkg::CHAR_CR);
   endtask

   // Place a call, then ticks with other events mixed in, sometimes a hangup.
   task automatic run_call(input int timeout_now);
      int n;
      send_event(mrcs_pkg::CMD_PLACE);
      n = $urandom_range(0, (timeout_now < 28) ? timeout_now + 3 : 30);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: send_event(mrcs_pkg::CMD_MUTE);
            1: send_event(mrcs_pkg::CMD_ANSWER);
            2: send_line(pick_body());
            default: send_event(mrcs_pkg::CMD_TICK);
         endcase
      end
      if ($urandom_range(0, 1)) send_event(mrcs_pkg::CMD_HANGUP);
   endtask

   // Write the timeout register once every response has drained.
   task automatic write_timeout(input logic [15:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Main stimulus.
   initial begin
      logic [7:0] opening_bytes [15];
      logic [2:0] opening_ops [7];
      logic [15:0] settings [SETTING_COUNT];
      int start_count;
      int pick;
      int k;

      req_ch.valid = 1'b0;
      req_ch.cmd = mrcs_pkg::CMD_RX_BYTE;
      req_ch.rx_byte = 8'h00;

      // Empty line, OK, a bare +CMGL, and OK cut short by a zero byte before junk.
      opening_bytes = '{mrcs_pkg::CHAR_CR, "O", "K", mrcs_pkg::CHAR_LF, "+", "C", "M", "G",
                        "L", mrcs_pkg::CHAR_CR, "O", "K", 8'h00, 8'hFF, mrcs_pkg::CHAR_CR};
      opening_ops = '{mrcs_pkg::CMD_PLACE, mrcs_pkg::CMD_MUTE, mrcs_pkg::CMD_TICK,
                      mrcs_pkg::CMD_ANSWER, mrcs_pkg::CMD_HANGUP, CMD_UNUSED,
                      mrcs_pkg::CMD_CLEAR};
      settings = '{mrcs_pkg::CONNECT_TIMEOUT_RESET, 16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd9,
                   16'($urandom_range(3, 40))};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_bytes[i]) send_item(mrcs_pkg::CMD_RX_BYTE, opening_bytes[i]);
      foreach (opening_ops[i]) send_event(opening_ops[i]);

      // Random traffic under each timeout setting; the first keeps the reset value.
      for (k = 0; k < SETTING_COUNT; k++) begin
         if (k > 0) write_timeout(settings[k]);
         steady = (k == 3);
         if (k == 1 || k == 5) send_long_line();
         start_count = items_sent;
         while (items_sent - start_count < ITEMS_PER_SETTING) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_line(pick_body());
            end else if (pick < 65) begin
               run_call(int'(settings[k]));
            end else if (pick < 85) begin
               send_event(3'($urandom_range(1, 7)));
            end else begin
               repeat ($urandom_range(1, 6))
                  send_item(mrcs_pkg::CMD_RX_BYTE, 8'($urandom_range(0, 255)));
            end
         end
      end
      steady = 1'b0;

      // Let every response drain, then let anything stray arrive before the verdict.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d items across %0d timeout settings; %0d responses compared.",
               items_sent, SETTING_COUNT, results_checked);
      $display("%0d lines classified, %0d connect timeouts expired, %0d failures.",
               lines_closed, timeouts_seen, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mrcs_pkg.sv
rtl/mrcs_channels.sv
rtl/modem_response_and_call_state.sv
verif/mrcs_checker.sv
verif/testbench.sv
